### rtl/core/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int DIV_STEPS = DATA_W;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    // One result part in sign-magnitude form while the quotient is built.
    // For add and multiply num already holds the magnitude.
    typedef struct packed {
        logic              s;
        logic              huge;
        logic [PROD_W-1:0] rem;
        logic [DATA_W-1:0] num;
    } t_div_part;

    typedef struct packed {
        t_op               op;
        logic              dbz;
        logic [PROD_W-1:0] d;
        t_div_part         re;
        t_div_part         im;
    } t_div_item;

endpackage
`default_nettype wire

### rtl/core/complex_arith_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Complex add, multiply and divide on signed fixed-point operands.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while o_stall is low and returns one result
// per transaction, in order. Four stages form the operand magnitudes, the six
// 32x32 products and the signed sums; one stage scales and sets up the
// quotient; 32 stages of the restoring divider each retire one quotient bit;
// a final register saturates. Add and multiply ride the same pipeline so
// results never reorder. A skid register at the output holds one result while
// the pipeline is frozen.
// ----------------------------------------------------------------------------
module complex_arith_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic signed [31:0] i_a_real,
    input  wire logic signed [31:0] i_a_imag,
    input  wire logic signed [31:0] i_b_real,
    input  wire logic signed [31:0] i_b_imag,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_imag,
    output logic             o_div_by_zero,
    output logic             o_overflow
);
    import cau_pkg::*;

    localparam int NUM_W = PROD_W + FRAC_BITS;

    logic w_en;

    // stage 1: signs, magnitudes, add sums
    logic              r_s1_vld;
    t_op               r_s1_op;
    logic [3:0]        r_s1_sg;
    logic [DATA_W-1:0] r_s1_mar, r_s1_mai, r_s1_mbr, r_s1_mbi;
    logic [DATA_W:0]   r_s1_sum_re, r_s1_sum_im;

    // stage 2: products
    logic              r_s2_vld;
    t_op               r_s2_op;
    logic [3:0]        r_s2_psg;
    logic [PROD_W-1:0] r_s2_rr, r_s2_ii, r_s2_ri, r_s2_ir, r_s2_dr, r_s2_di;
    logic              r_s2_add_s_re, r_s2_add_s_im;
    logic [DATA_W:0]   r_s2_add_m_re, r_s2_add_m_im;

    // stage 3: signed combinations
    logic              r_s3_vld;
    t_op               r_s3_op;
    logic [PROD_W:0]   r_s3_v_re, r_s3_v_im;
    logic [PROD_W-1:0] r_s3_d;
    logic              r_s3_add_s_re, r_s3_add_s_im;
    logic [DATA_W:0]   r_s3_add_m_re, r_s3_add_m_im;

    // stage 4: magnitudes
    logic              r_s4_vld;
    t_op               r_s4_op;
    logic              r_s4_s_re, r_s4_s_im;
    logic [PROD_W-1:0] r_s4_m_re, r_s4_m_im;
    logic [PROD_W-1:0] r_s4_d;
    logic              r_s4_add_s_re, r_s4_add_s_im;
    logic [DATA_W:0]   r_s4_add_m_re, r_s4_add_m_im;

    // stage 5: divider entry
    logic              r_s5_vld;
    t_div_item         r_s5_item;
    t_div_item         n_s5_item;

    // output and skid
    logic              r_ov, r_skid_v;
    logic [DATA_W-1:0] r_res_re, r_res_im;
    logic              r_dbz, r_ovf;
    logic [DATA_W-1:0] r_sk_re, r_sk_im;
    logic              r_sk_dbz, r_sk_ovf;

    logic              w_vld [0:DIV_STEPS];
    t_div_item         w_item [0:DIV_STEPS];

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : v;
    endfunction

    function automatic logic [PROD_W:0] sval(input logic [PROD_W-1:0] p, input logic sg);
        return sg ? (PROD_W+1)'(-{1'b0, p}) : {1'b0, p};
    endfunction

    // ---------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op     <= t_op'(i_op);
            r_s1_sg     <= {i_a_real[31], i_a_imag[31], i_b_real[31], i_b_imag[31]};
            r_s1_mar    <= mag32(i_a_real);
            r_s1_mai    <= mag32(i_a_imag);
            r_s1_mbr    <= mag32(i_b_real);
            r_s1_mbi    <= mag32(i_b_imag);
            r_s1_sum_re <= {i_a_real[31], i_a_real} + {i_b_real[31], i_b_real};
            r_s1_sum_im <= {i_a_imag[31], i_a_imag} + {i_b_imag[31], i_b_imag};
        end
    end

    // ---------------- stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // r_s1_sg order: ar, ai, br, bi; r_s2_psg order: rr, ii, ri, ir
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_op       <= r_s1_op;
            r_s2_psg      <= {r_s1_sg[3] ^ r_s1_sg[1], r_s1_sg[2] ^ r_s1_sg[0],
                              r_s1_sg[3] ^ r_s1_sg[0], r_s1_sg[2] ^ r_s1_sg[1]};
            r_s2_rr       <= r_s1_mar * r_s1_mbr;
            r_s2_ii       <= r_s1_mai * r_s1_mbi;
            r_s2_ri       <= r_s1_mar * r_s1_mbi;
            r_s2_ir       <= r_s1_mai * r_s1_mbr;
            r_s2_dr       <= r_s1_mbr * r_s1_mbr;
            r_s2_di       <= r_s1_mbi * r_s1_mbi;
            r_s2_add_s_re <= r_s1_sum_re[DATA_W];
            r_s2_add_s_im <= r_s1_sum_im[DATA_W];
            r_s2_add_m_re <= r_s1_sum_re[DATA_W] ? (DATA_W+1)'(-r_s1_sum_re) : r_s1_sum_re;
            r_s2_add_m_im <= r_s1_sum_im[DATA_W] ? (DATA_W+1)'(-r_s1_sum_im) : r_s1_sum_im;
        end
    end

    // ---------------- stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_op <= r_s2_op;
            if (r_s2_op == OP_DIV) begin
                r_s3_v_re <= sval(r_s2_rr, r_s2_psg[3]) + sval(r_s2_ii, r_s2_psg[2]);
                r_s3_v_im <= sval(r_s2_ir, r_s2_psg[0]) + sval(r_s2_ri, !r_s2_psg[1]);
            end else begin
                r_s3_v_re <= sval(r_s2_rr, r_s2_psg[3]) + sval(r_s2_ii, !r_s2_psg[2]);
                r_s3_v_im <= sval(r_s2_ri, r_s2_psg[1]) + sval(r_s2_ir, r_s2_psg[0]);
            end
            r_s3_d        <= r_s2_dr + r_s2_di;
            r_s3_add_s_re <= r_s2_add_s_re;
            r_s3_add_s_im <= r_s2_add_s_im;
            r_s3_add_m_re <= r_s2_add_m_re;
            r_s3_add_m_im <= r_s2_add_m_im;
        end
    end

    // ---------------- stage 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_en) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_op       <= r_s3_op;
            r_s4_s_re     <= r_s3_v_re[PROD_W];
            r_s4_s_im     <= r_s3_v_im[PROD_W];
            r_s4_m_re     <= r_s3_v_re[PROD_W] ? PROD_W'(-r_s3_v_re) : r_s3_v_re[PROD_W-1:0];
            r_s4_m_im     <= r_s3_v_im[PROD_W] ? PROD_W'(-r_s3_v_im) : r_s3_v_im[PROD_W-1:0];
            r_s4_d        <= r_s3_d;
            r_s4_add_s_re <= r_s3_add_s_re;
            r_s4_add_s_im <= r_s3_add_s_im;
            r_s4_add_m_re <= r_s3_add_m_re;
            r_s4_add_m_im <= r_s3_add_m_im;
        end
    end

    // ---------------- stage 5: scale and set up the quotient
    function automatic t_div_part setup(input t_op op, input logic s,
                                        input logic [PROD_W-1:0] m,
                                        input logic [PROD_W-1:0] d,
                                        input logic add_s, input logic [DATA_W:0] add_m);
        logic [NUM_W-1:0]        nfull;
        logic [NUM_W-DATA_W-1:0] hi;
        logic [PROD_W-1:0]       mm;
        t_div_part               p;
        nfull = {m, {FRAC_BITS{1'b0}}};
        hi    = nfull[NUM_W-1:DATA_W];
        mm    = m >> FRAC_BITS;
        p     = '0;
        unique case (op)
            OP_ADD: begin
                p.s    = add_s;
                p.huge = add_m[DATA_W];
                p.num  = add_m[DATA_W-1:0];
            end
            OP_MUL: begin
                p.s    = s;
                p.huge = |mm[PROD_W-1:DATA_W];
                p.num  = mm[DATA_W-1:0];
            end
            OP_DIV: begin
                p.s    = s;
                p.huge = (PROD_W'(hi) >= d);
                p.rem  = PROD_W'(hi);
                p.num  = nfull[DATA_W-1:0];
            end
            default: begin
                p = '0;
            end
        endcase
        return p;
    endfunction

    always_comb begin
        n_s5_item.op  = r_s4_op;
        n_s5_item.d   = r_s4_d;
        n_s5_item.dbz = (r_s4_op == OP_DIV) && (r_s4_d == '0);
        n_s5_item.re  = setup(r_s4_op, r_s4_s_re, r_s4_m_re, r_s4_d,
                              r_s4_add_s_re, r_s4_add_m_re);
        n_s5_item.im  = setup(r_s4_op, r_s4_s_im, r_s4_m_im, r_s4_d,
                              r_s4_add_s_im, r_s4_add_m_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_item <= n_s5_item;
        end
    end

    // ---------------- divider stages
    assign w_vld[0]  = r_s5_vld;
    assign w_item[0] = r_s5_item;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        cau_div_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_vld[g]),
            .i_item (w_item[g]),
            .o_vld  (w_vld[g+1]),
            .o_item (w_item[g+1])
        );
    end

    // ---------------- saturation
    function automatic logic [DATA_W:0] sat(input t_div_part p, input logic zero);
        logic [DATA_W:0] r;
        r = '0;
        if (zero || (p.num == '0 && !p.huge)) begin
            r = '0;
        end else if (!p.s) begin
            if (p.huge || p.num[DATA_W-1]) r = {1'b1, SAT_POS};
            else                           r = {1'b0, p.num};
        end else begin
            if (p.huge || (p.num[DATA_W-1] && |p.num[DATA_W-2:0])) r = {1'b1, SAT_NEG};
            else                                                     r = {1'b0, DATA_W'(-p.num)};
        end
        return r;
    endfunction

    logic              w_zero;
    logic [DATA_W:0]   w_sat_re, w_sat_im;
    logic              w_out_free;
    t_div_item         w_last;

    assign w_last     = w_item[DIV_STEPS];
    assign w_zero     = w_last.dbz || (w_last.op == OP_NOP);
    assign w_sat_re   = sat(w_last.re, w_zero);
    assign w_sat_im   = sat(w_last.im, w_zero);
    assign w_out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_free) begin
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_vld[DIV_STEPS]) begin
            if (w_out_free) r_ov     <= 1'b1;
            else            r_skid_v <= 1'b1;
        end else if (w_out_free) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_out_free) begin
                r_res_re <= r_sk_re;
                r_res_im <= r_sk_im;
                r_dbz    <= r_sk_dbz;
                r_ovf    <= r_sk_ovf;
            end
        end else if (w_vld[DIV_STEPS]) begin
            if (w_out_free) begin
                r_res_re <= w_sat_re[DATA_W-1:0];
                r_res_im <= w_sat_im[DATA_W-1:0];
                r_dbz    <= w_last.dbz;
                r_ovf    <= w_sat_re[DATA_W] | w_sat_im[DATA_W];
            end else begin
                r_sk_re  <= w_sat_re[DATA_W-1:0];
                r_sk_im  <= w_sat_im[DATA_W-1:0];
                r_sk_dbz <= w_last.dbz;
                r_sk_ovf <= w_sat_re[DATA_W] | w_sat_im[DATA_W];
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_res_real    = r_res_re;
    assign o_res_imag    = r_res_im;
    assign o_div_by_zero = r_dbz;
    assign o_overflow    = r_ovf;

`ifndef SYNTHESIS
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_res_real == '0 && o_res_imag == '0 && !o_overflow)
        else $error("divide by zero result not cleared");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid holds a transaction while output is empty");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_res_real == SAT_POS || o_res_real == SAT_NEG ||
                                  o_res_imag == SAT_POS || o_res_imag == SAT_NEG)
        else $error("overflow without a saturated part");
`endif

endmodule
`default_nettype wire

### rtl/core/cau_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring-division stage: one quotient bit for each result part.
// ----------------------------------------------------------------------------
module cau_div_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire cau_pkg::t_div_item i_item,
    output logic                    o_vld,
    output cau_pkg::t_div_item      o_item
);
    import cau_pkg::*;

    logic      r_vld;
    t_div_item r_item;
    t_div_item n_item;

    function automatic t_div_part step(input t_div_part p, input logic [PROD_W-1:0] d);
        logic [PROD_W:0] r2;
        logic            ge;
        t_div_part       q;
        r2     = {p.rem, p.num[DATA_W-1]};
        ge     = (r2 >= {1'b0, d});
        q      = p;
        q.rem  = ge ? PROD_W'(r2 - {1'b0, d}) : r2[PROD_W-1:0];
        q.num  = {p.num[DATA_W-2:0], ge};
        return q;
    endfunction

    always_comb begin
        n_item = i_item;
        if (i_item.op == OP_DIV) begin
            n_item.re = step(i_item.re, i_item.d);
            n_item.im = step(i_item.im, i_item.d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives random and corner-case add, multiply and divide transactions through
// the unit with random idle and stall cycles, predicts each result with exact
// wide arithmetic, and checks results in order against the expectations.
// ----------------------------------------------------------------------------
module testbench;
    import cau_pkg::*;

    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 1600;
    localparam int MAX_CYC   = 400000;
    localparam int DRAIN_CYC = 80;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        dbz;
        logic        ovf;
    } t_cplx_res;

    class cplx_scoreboard;
        t_cplx_res pending[$];
        int        n_bad;

        function new();
            n_bad = 0;
        endfunction

        // Saturate a signed exact value given as sign and magnitude.
        function logic [31:0] clamp(logic neg, logic [129:0] mag, inout logic ovf);
            logic [31:0] w;
            if (!neg) begin
                if (mag > 130'h7FFF_FFFF) begin
                    ovf = 1'b1;
                    w = SAT_POS;
                end else begin
                    w = mag[31:0];
                end
            end else begin
                if (mag > 130'h8000_0000) begin
                    ovf = 1'b1;
                    w = SAT_NEG;
                end else begin
                    w = -mag[31:0];
                end
            end
            return w;
        endfunction

        function void note(t_op op, logic signed [31:0] ar, logic signed [31:0] ai,
                           logic signed [31:0] br, logic signed [31:0] bi);
            t_cplx_res r;
            logic signed [65:0] nre, nim, dsum;
            logic [129:0] mre, mim;
            r = '{re: '0, im: '0, dbz: 1'b0, ovf: 1'b0};
            nre = '0;
            nim = '0;
            dsum = 66'(br) * 66'(br) + 66'(bi) * 66'(bi);
            case (op)
                OP_ADD: begin
                    nre = 66'(ar) + 66'(br);
                    nim = 66'(ai) + 66'(bi);
                end
                OP_MUL: begin
                    nre = 66'(ar) * 66'(br) - 66'(ai) * 66'(bi);
                    nim = 66'(ar) * 66'(bi) + 66'(ai) * 66'(br);
                end
                OP_DIV: begin
                    nre = 66'(ar) * 66'(br) + 66'(ai) * 66'(bi);
                    nim = 66'(ai) * 66'(br) - 66'(ar) * 66'(bi);
                end
                default: ;
            endcase
            mre = 130'(nre < 0 ? -nre : nre);
            mim = 130'(nim < 0 ? -nim : nim);
            if (op == OP_MUL) begin
                mre = mre >> FRAC;
                mim = mim >> FRAC;
            end else if (op == OP_DIV && dsum != 0) begin
                mre = (mre << FRAC) / 130'(dsum);
                mim = (mim << FRAC) / 130'(dsum);
            end
            if (op == OP_DIV && dsum == 0) begin
                r.dbz = 1'b1;
            end else if (op != OP_NOP) begin
                r.re = clamp(nre < 0, mre, r.ovf);
                r.im = clamp(nim < 0, mim, r.ovf);
            end
            pending.push_back(r);
        endfunction

        function void check(t_cplx_res got);
            t_cplx_res exp_r;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result re=%h im=%h", got.re, got.im);
                return;
            end
            exp_r = pending.pop_front();
            if (got.re !== exp_r.re || got.im !== exp_r.im ||
                got.dbz !== exp_r.dbz || got.ovf !== exp_r.ovf) begin
                n_bad++;
                if (n_bad <= 10)
                    $display({"mismatch: exp re=%h im=%h dbz=%b ovf=%b,",
                              " got re=%h im=%h dbz=%b ovf=%b"},
                             exp_r.re, exp_r.im, exp_r.dbz, exp_r.ovf,
                             got.re, got.im, got.dbz, got.ovf);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [1:0]  i_op = OP_ADD;
    logic signed [31:0] i_a_real = '0, i_a_imag = '0, i_b_real = '0, i_b_imag = '0;
    logic        o_stall, o_valid, o_div_by_zero, o_overflow;
    logic signed [31:0] o_res_real, o_res_imag;

    logic quiet = 1'b0;
    int   cycles = 0;
    cplx_scoreboard sb = new();

    complex_arith_unit_top #(.FRAC_BITS(FRAC)) DUT (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op,
        .i_a_real, .i_a_imag, .i_b_real, .i_b_imag,
        .o_valid, .i_stall, .o_res_real, .o_res_imag,
        .o_div_by_zero, .o_overflow
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note(t_op'(i_op), i_a_real, i_a_imag, i_b_real, i_b_imag);
            if (o_valid && !i_stall)
                sb.check('{re: o_res_real, im: o_res_imag,
                           dbz: o_div_by_zero, ovf: o_overflow});
        end
    end

    always @(negedge i_clk) begin
        i_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 19);
    end

    task automatic send(logic [1:0] op, logic [31:0] ar, logic [31:0] ai,
                        logic [31:0] br, logic [31:0] bi);
        while (!quiet && $urandom_range(0, 99) < 19) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mix full-range words with values near unity and a few extremes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2:    return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
            3:    return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            4:    return $urandom() >> $urandom_range(0, 31);
            default: begin
                case ($urandom_range(0, 3))
                    0: return SAT_POS;
                    1: return SAT_NEG;
                    2: return 32'h0001_0000;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    initial begin
        logic [31:0] br, bi;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, zero divisor, unused op code, saturation
        send(OP_ADD, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG);
        send(OP_ADD, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS);
        send(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
        send(OP_MUL, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
        send(OP_MUL, SAT_POS, SAT_NEG, SAT_NEG, SAT_POS);
        send(OP_MUL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        send(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
        send(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        send(OP_DIV, SAT_POS, SAT_NEG, 32'h0, 32'h0);
        send(OP_DIV, 32'h0001_0000, 32'h0, 32'h0000_0001, 32'h0);
        send(OP_DIV, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
        send(OP_DIV, SAT_POS, SAT_POS, 32'h0000_0001, 32'hFFFF_FFFF);
        send(OP_DIV, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000);
        send(OP_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0);
        send(OP_NOP, SAT_POS, SAT_NEG, 32'h1234_5678, 32'h0);
        send(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet <= (n >= 600 && n < 900);
            br = pick_word();
            bi = pick_word();
            if ($urandom_range(0, 19) == 0) begin
                br = '0;
                bi = '0;
            end
            send($urandom_range(0, 15) == 0 ? OP_NOP : 2'($urandom_range(0, 2)),
                 pick_word(), pick_word(), br, bi);
        end
        i_valid <= 1'b0;
        quiet   <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### files.f
rtl/core/cau_pkg.sv
rtl/core/cau_div_step.sv
rtl/core/complex_arith_unit_top.sv
tb/testbench.sv
